FILE: src/rce_pkg.sv
// ============================================================================
// rce_pkg
// Shared types, constants and helpers of the retargetable cubic easing unit.
// ============================================================================
`default_nettype none

package rce_pkg;

	// Working widths: signed Horner terms, their magnitude and its two chunks
	localparam int XW  = 48;
	localparam int MW  = XW - 1;
	localparam int LW  = 24;
	localparam int HW  = MW - LW;
	localparam int VW  = 32;
	localparam int SLW = 40;
	localparam int BW  = 16;

	localparam logic [BW-1:0] BLEND_RESET = 16'd200;

	// Command codes of an input word
	localparam logic CMD_DECLARE = 1'b0;
	localparam logic CMD_SAMPLE  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV,
		ST_MUL,
		ST_FIN
	} ctl_state_t;

	// Operand of each Horner multiply, in issue order
	typedef enum logic [2:0] {
		OP_A,
		OP_PB,
		OP_PC,
		OP_A3,
		OP_QB2
	} mul_op_t;

	// Steps of one multiply by normalized time
	typedef enum logic [2:0] {
		MS_FORM,
		MS_ABS,
		MS_LO,
		MS_HI,
		MS_SUM,
		MS_OUT
	} mul_stage_t;

	typedef struct packed {
		logic       load;
		logic       prep;
		logic       div_step;
		logic       mul_en;
		mul_op_t    mul_op;
		mul_stage_t mul_stage;
		logic       fin;
	} dp_cmd_t;

	typedef struct packed {
		logic out_busy;
	} dp_status_t;

	// Saturate a working value to 32-bit signed
	function automatic logic signed [VW-1:0] sat32(input logic signed [XW-1:0] x);
		logic signed [VW-1:0] r;
		if ((&x[XW-1:VW-1]) || !(|x[XW-1:VW-1])) begin
			r = x[VW-1:0];
		end else if (x[XW-1]) begin
			r = {1'b1, {(VW-1){1'b0}}};
		end else begin
			r = {1'b0, {(VW-1){1'b1}}};
		end
		return r;
	endfunction

	// Saturate a working value to 40-bit signed
	function automatic logic signed [SLW-1:0] sat40(input logic signed [XW-1:0] x);
		logic signed [SLW-1:0] r;
		if ((&x[XW-1:SLW-1]) || !(|x[XW-1:SLW-1])) begin
			r = x[SLW-1:0];
		end else if (x[XW-1]) begin
			r = {1'b1, {(SLW-1){1'b0}}};
		end else begin
			r = {1'b0, {(SLW-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: src/rce_cfg_if.sv
// ============================================================================
// rce_cfg_if
// Configuration write channel carrying the blend duration.
// ============================================================================
`default_nettype none

interface rce_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] blend_ticks;

	modport source (output valid, output blend_ticks, input ready);
	modport sink (input valid, input blend_ticks, output ready);
endinterface

`default_nettype wire

FILE: src/rce_in_if.sv
// ============================================================================
// rce_in_if
// Command channel: declare a target or sample the curve.
// ============================================================================
`default_nettype none

interface rce_in_if;
	logic               valid;
	logic               ready;
	logic               command;
	logic [31:0]        now_tick;
	logic signed [31:0] new_goal;

	modport source (output valid, output command, output now_tick, output new_goal,
		input ready);
	modport sink (input valid, input command, input now_tick, input new_goal,
		output ready);
endinterface

`default_nettype wire

FILE: src/rce_out_if.sv
// ============================================================================
// rce_out_if
// Result channel: curve value and still-moving flag.
// ============================================================================
`default_nettype none

interface rce_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] value;
	logic               moving;

	modport source (output valid, output value, output moving, input ready);
	modport sink (input valid, input value, input moving, output ready);
endinterface

`default_nettype wire

FILE: src/retargetable_cubic_easing_unit.sv
// ============================================================================
// retargetable_cubic_easing_unit
// Cubic ease-out toward a movable target, sampled on command.
// ============================================================================
// Sequence: from the accepted word to a valid result, a prep step, one divider
// step per time fraction bit, then five multiplies by time through one shared
// unit, each in the steps form, abs, low and high products, sum and output.
// A new word is taken only after writeback, but it is taken while the
// previous result still waits in the output register.
// Reset: asynchronous, clears curve state to zero and blend_ticks to 200.
`default_nettype none

module retargetable_cubic_easing_unit #(
	parameter int VALUE_FRAC_BITS = 16,
	parameter int TIME_FRAC_BITS  = 16
) (
	input wire         clk,
	input wire         arst_n,
	rce_cfg_if.sink    cfg,
	rce_in_if.sink     req,
	rce_out_if.source  rsp
);
	import rce_pkg::*;

	dp_cmd_t    ctl_cmd;
	dp_status_t dp_status;
	logic       ctl_idle;
	logic       in_accept;

	// Accept a word only while the sequencer is idle
	assign req.ready = ctl_idle;
	assign cfg.ready = 1'b1;
	assign in_accept = req.valid && ctl_idle;

	rce_controller #(
		.TIME_FRAC_BITS(TIME_FRAC_BITS)
	) u_ctl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_accept(in_accept),
		.status   (dp_status),
		.cmd      (ctl_cmd),
		.idle     (ctl_idle)
	);

	rce_datapath #(
		.VALUE_FRAC_BITS(VALUE_FRAC_BITS),
		.TIME_FRAC_BITS (TIME_FRAC_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (ctl_cmd),
		.status         (dp_status),
		.cfg_write      (cfg.valid),
		.cfg_blend_ticks(cfg.blend_ticks),
		.in_command     (req.command),
		.in_now_tick    (req.now_tick),
		.in_new_goal    (req.new_goal),
		.out_valid      (rsp.valid),
		.out_ready      (rsp.ready),
		.out_value      (rsp.value),
		.out_moving     (rsp.moving)
	);

	// One word in flight at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> !req.ready)
		else $error("word accepted while previous one in flight");

	// Never overwrite an untaken result
	a_fin_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_cmd.fin |-> !dp_status.out_busy)
		else $error("result register overwritten");

	// A result appears only after writeback
	a_valid_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(ctl_cmd.fin))
		else $error("result valid without writeback");

	// Datapath commands are mutually exclusive
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl_cmd.load, ctl_cmd.prep, ctl_cmd.div_step, ctl_cmd.mul_en, ctl_cmd.fin}))
		else $error("overlapping datapath commands");

endmodule

`default_nettype wire

FILE: src/rce_controller.sv
// ============================================================================
// rce_controller
// Sequencer: load, prep, time division, five Horner multiplies, then writeback.
// ============================================================================
`default_nettype none

module rce_controller #(
	parameter int TIME_FRAC_BITS = 16
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      in_accept,
	input  wire rce_pkg::dp_status_t status,
	output rce_pkg::dp_cmd_t         cmd,
	output logic                     idle
);
	import rce_pkg::*;

	localparam int CNTW = $clog2(TIME_FRAC_BITS);
	localparam logic [CNTW-1:0] DIV_LAST = CNTW'(TIME_FRAC_BITS - 1);

	ctl_state_t       state_q, state_d;
	logic [CNTW-1:0]  cnt_q, cnt_d;
	mul_op_t          op_q, op_d;
	mul_stage_t       stage_q, stage_d;

	function automatic mul_op_t next_op(input mul_op_t op);
		mul_op_t r;
		unique case (op)
			OP_A:    r = OP_PB;
			OP_PB:   r = OP_PC;
			OP_PC:   r = OP_A3;
			OP_A3:   r = OP_QB2;
			default: r = OP_A;
		endcase
		return r;
	endfunction

	function automatic mul_stage_t next_stage(input mul_stage_t st);
		mul_stage_t r;
		unique case (st)
			MS_FORM: r = MS_ABS;
			MS_ABS:  r = MS_LO;
			MS_LO:   r = MS_HI;
			MS_HI:   r = MS_SUM;
			MS_SUM:  r = MS_OUT;
			default: r = MS_FORM;
		endcase
		return r;
	endfunction

	// State, step counter and multiply position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			op_q    <= OP_A;
			stage_q <= MS_FORM;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			op_q    <= op_d;
			stage_q <= stage_d;
		end
	end

	// Next state and datapath commands
	always_comb begin
		state_d       = state_q;
		cnt_d         = cnt_q;
		op_d          = op_q;
		stage_d       = stage_q;
		idle          = 1'b0;
		cmd.load      = 1'b0;
		cmd.prep      = 1'b0;
		cmd.div_step  = 1'b0;
		cmd.mul_en    = 1'b0;
		cmd.mul_op    = op_q;
		cmd.mul_stage = stage_q;
		cmd.fin       = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				idle = 1'b1;
				if (in_accept) begin
					cmd.load = 1'b1;
					state_d  = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				cnt_d    = '0;
				state_d  = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == DIV_LAST) begin
					op_d    = OP_A;
					stage_d = MS_FORM;
					state_d = ST_MUL;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_MUL: begin
				cmd.mul_en = 1'b1;
				if (stage_q == MS_OUT) begin
					stage_d = MS_FORM;
					if (op_q == OP_QB2) begin
						state_d = ST_FIN;
					end else begin
						op_d = next_op(op_q);
					end
				end else begin
					stage_d = next_stage(stage_q);
				end
			end
			ST_FIN: begin
				// hold until the result register is free
				if (!status.out_busy) begin
					cmd.fin = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: src/rce_datapath.sv
// ============================================================================
// rce_datapath
// Curve state, time divider, shared multiply-by-time unit and result register.
// ============================================================================
`default_nettype none

module rce_datapath #(
	parameter int VALUE_FRAC_BITS = 16,
	parameter int TIME_FRAC_BITS  = 16
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire rce_pkg::dp_cmd_t    cmd,
	output rce_pkg::dp_status_t      status,
	input  wire                      cfg_write,
	input  wire  [15:0]              cfg_blend_ticks,
	input  wire                      in_command,
	input  wire  [31:0]              in_now_tick,
	input  wire  signed [31:0]       in_new_goal,
	output logic                     out_valid,
	input  wire                      out_ready,
	output logic signed [31:0]       out_value,
	output logic                     out_moving
);
	import rce_pkg::*;

	localparam int TW  = TIME_FRAC_BITS + 1;
	localparam int PLW = LW + TW;
	localparam int PHW = HW + TW;
	localparam int SW  = MW + TW;
	localparam logic [TW-1:0] T_ONE = TW'(1) << TIME_FRAC_BITS;
	localparam logic signed [VW:0] HALF = (VW+1)'(1) <<< (VALUE_FRAC_BITS - 1);

	// Configuration and curve state
	logic [BW-1:0]         blend_q;
	logic                  started_q;
	logic signed [VW-1:0]  goal_q;
	logic signed [VW-1:0]  sv_q;
	logic signed [SLW-1:0] slope_q;
	logic [VW-1:0]         start_tick_q;

	// Current word and its precomputed terms
	logic                  cmd_q;
	logic [VW-1:0]         now_q;
	logic signed [VW-1:0]  want_q;
	logic signed [VW:0]    span_q;
	logic signed [VW:0]    diff_q;
	logic [VW-1:0]         elapsed_q;
	logic signed [XW-1:0]  a_q;
	logic signed [XW-1:0]  b_q;
	logic                  ignore_q;

	// Divider
	logic [BW-1:0]         rem_q;
	logic [TW-1:0]         quo_q;
	logic                  frozen_q;

	// Multiply unit
	logic signed [XW-1:0]  x_q;
	logic                  neg_q;
	logic [MW-1:0]         mag_q;
	logic [PLW-1:0]        pplo_q;
	logic [PHW-1:0]        pphi_q;
	logic [SW-1:0]         sum_q;
	logic signed [XW-1:0]  prod_q;
	logic signed [XW-1:0]  p3_q;

	// Result register
	logic                  out_valid_q;
	logic signed [VW-1:0]  out_value_q;
	logic                  out_moving_q;

	logic [BW-1:0]         span_ticks;
	logic [BW:0]           rem_x2;
	logic                  rem_ge;
	logic signed [XW-1:0]  x_sel;
	logic [MW-1:0]         prod_mag;
	logic signed [XW-1:0]  prod_new;
	logic signed [XW-1:0]  val_full;
	logic signed [XW-1:0]  slope_full;
	logic signed [VW-1:0]  val_sat;
	logic                  retarget;

	// Zero duration counts as one tick
	assign span_ticks = (blend_q == '0) ? BW'(1) : blend_q;

	// One restoring division step
	assign rem_x2 = {rem_q, 1'b0};
	assign rem_ge = rem_x2 >= {1'b0, span_ticks};

	// Select the operand of the next Horner multiply
	always_comb begin
		case (cmd.mul_op)
			OP_A:    x_sel = a_q;
			OP_PB:   x_sel = prod_q + b_q;
			OP_PC:   x_sel = prod_q + XW'(slope_q);
			OP_A3:   x_sel = a_q + (a_q <<< 1);
			OP_QB2:  x_sel = prod_q + (b_q <<< 1);
			default: x_sel = a_q;
		endcase
	end

	// Drop time fraction bits and reapply the sign
	assign prod_mag = MW'(sum_q >> TIME_FRAC_BITS);
	assign prod_new = neg_q ? -$signed({1'b0, prod_mag}) : $signed({1'b0, prod_mag});

	// Final curve value and slope
	assign val_full   = p3_q + XW'(sv_q);
	assign slope_full = prod_q + XW'(slope_q);
	assign val_sat    = sat32(val_full);
	assign retarget   = (cmd_q == CMD_DECLARE) && !ignore_q;

	// Configuration, curve state and result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blend_q      <= BLEND_RESET;
			started_q    <= 1'b0;
			goal_q       <= '0;
			sv_q         <= '0;
			slope_q      <= '0;
			start_tick_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_write) begin
				blend_q <= cfg_blend_ticks;
			end
			if (cmd.fin && retarget) begin
				goal_q <= want_q;
				if (!started_q) begin
					started_q <= 1'b1;
					sv_q      <= want_q;
					slope_q   <= '0;
				end else begin
					sv_q         <= val_sat;
					slope_q      <= sat40(slope_full);
					start_tick_q <= now_q;
				end
			end
			if (cmd.fin) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q     <= in_command;
			now_q     <= in_now_tick;
			want_q    <= in_new_goal;
			span_q    <= (VW+1)'(goal_q) - (VW+1)'(sv_q);
			diff_q    <= (VW+1)'(in_new_goal) - (VW+1)'(goal_q);
			elapsed_q <= in_now_tick - start_tick_q;
		end
		if (cmd.prep) begin
			a_q      <= XW'(slope_q) - (XW'(span_q) <<< 1);
			b_q      <= XW'(span_q) + (XW'(span_q) <<< 1) - (XW'(slope_q) <<< 1);
			ignore_q <= (diff_q > -HALF) && (diff_q < HALF);
			// negative elapsed clamps to zero, a full span to one
			if (elapsed_q[VW-1]) begin
				quo_q    <= '0;
				frozen_q <= 1'b1;
			end else if (elapsed_q >= VW'(span_ticks)) begin
				quo_q    <= T_ONE;
				frozen_q <= 1'b1;
			end else begin
				quo_q    <= '0;
				rem_q    <= elapsed_q[BW-1:0];
				frozen_q <= 1'b0;
			end
		end
		if (cmd.div_step && !frozen_q) begin
			rem_q <= rem_ge ? BW'(rem_x2 - {1'b0, span_ticks}) : rem_x2[BW-1:0];
			quo_q <= {quo_q[TW-2:0], rem_ge};
		end
		if (cmd.mul_en) begin
			case (cmd.mul_stage)
				MS_FORM: begin
					x_q <= x_sel;
				end
				MS_ABS: begin
					neg_q <= x_q[XW-1];
					mag_q <= x_q[XW-1] ? MW'(-x_q) : MW'(x_q);
				end
				MS_LO: begin
					pplo_q <= PLW'(mag_q[LW-1:0]) * PLW'(quo_q);
				end
				MS_HI: begin
					pphi_q <= PHW'(mag_q[MW-1:LW]) * PHW'(quo_q);
				end
				MS_SUM: begin
					sum_q <= SW'(pplo_q) + (SW'(pphi_q) << LW);
				end
				MS_OUT: begin
					prod_q <= prod_new;
					if (cmd.mul_op == OP_PC) begin
						p3_q <= prod_new;
					end
				end
				default: begin
					x_q <= x_q;
				end
			endcase
		end
		if (cmd.fin) begin
			if (retarget) begin
				out_value_q  <= started_q ? val_sat : want_q;
				out_moving_q <= 1'b1;
			end else begin
				out_value_q  <= val_sat;
				out_moving_q <= quo_q != T_ONE;
			end
		end
	end

	assign status.out_busy = out_valid_q && !out_ready;
	assign out_valid       = out_valid_q;
	assign out_value       = out_value_q;
	assign out_moving      = out_moving_q;

endmodule

`default_nettype wire
